// ----- hw/rtl/ba_pkg.sv -----
// Buddy allocator package: pool geometry, free-flag word layout, codes and the
// command/status structs between controller and datapath. Depends on nothing.
package ba_pkg;

  localparam int NUM_UNITS = 256;
  localparam int LVL_CNT   = $clog2(NUM_UNITS + 1);
  localparam int UNIT_W    = LVL_CNT - 1;
  localparam int UNIT_CNT  = 1 << UNIT_W;
  localparam int LVL_W     = 4;
  localparam int WB        = 4;
  localparam int WORD_W    = 1 << WB;

  localparam logic [LVL_W-1:0] UNALLOC = 4'd15;

  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_NOSPACE = 2'd1;
  localparam logic [1:0] STS_BADFREE = 2'd2;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // words of free flags held for one level
  function automatic int words_of(int l);
    int b;
    b = UNIT_CNT >> l;
    return ((b >> WB) > 0) ? (b >> WB) : 1;
  endfunction

  // first word of a level; levels are packed from level 0 upward
  function automatic int base_of(int l);
    int s;
    s = 0;
    for (int i = 0; i < LVL_CNT; i++) begin
      if (i < l) s = s + words_of(i);
    end
    return s;
  endfunction

  localparam int WORDS = base_of(LVL_CNT);
  localparam int FA_W  = $clog2(WORDS);
  localparam int WC_W  = $clog2(words_of(0) + 1);

  typedef enum logic [3:0] {
    DP_NOP, DP_CLEAR, DP_LOAD, DP_LVL_INC, DP_SEARCH_INIT, DP_READ_SCAN,
    DP_SCAN_HIT, DP_WCNT_INC, DP_LVL_NEXT, DP_RMW_RD, DP_RMW_WR,
    DP_SPLIT_DOWN, DP_RECORD, DP_UNIT_RD, DP_FREE_START, DP_MERGE_UP
  } dp_op_t;

  typedef enum logic [1:0] {RMW_SET1, RMW_CLR1, RMW_SET2, RMW_CLR2} rmw_t;

  typedef struct packed {
    dp_op_t     op;
    rmw_t       rmw;
    logic       fin;
    logic [1:0] status;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_free;
    logic lvl_top;
    logic lvl_max;
    logic lvl_eq_tgt;
    logic size_above;
    logic hit;
    logic wcnt_last;
    logic unit_oob;
    logic lv_bad;
    logic pair_free;
    logic out_free;
  } dp_sts_t;

endpackage

// ----- hw/rtl/ba_if.sv -----
// Request, result and configuration channels of the buddy allocator.
// Depends on nothing.
interface ba_req_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [28:0] req_size;
  logic [27:0] free_offset;
  modport source (output valid, command, req_size, free_offset, input ready);
  modport sink   (input valid, command, req_size, free_offset, output ready);
endinterface

interface ba_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [27:0] block_offset;
  modport source (output valid, status, block_offset, input ready);
  modport sink   (input valid, status, block_offset, output ready);
endinterface

interface ba_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- hw/rtl/buddy_allocator_core.sv -----
// Top level of the buddy allocator: sequencer plus datapath.
// Depends on ba_pkg, ba_if, ba_ctrl, ba_dp.
//
// Binary buddy allocator over 256 minimum blocks of 2^min_block_shift bytes
// (shift 6 after reset, written on the cfg channel). Each request yields one
// result: status ok, no space / too large, or bad free, with the byte offset
// of an allocated block. Requests are handled one at a time by a sequencer
// driving a free-flag memory of 16-bit words with separate read and write
// ports (35 words, one read and one write a cycle) and a 256-entry level
// memory. An allocate rounds the size up one level at a time, scans flag
// words (up to 35 words when the pool is nearly full) and splits the found
// block one level at a time; a free merges one buddy pair per level, and a
// rejected free ends before any flag is touched. After reset a clearing
// pass initialises both memories; requests wait for it, configuration
// writes do not. The result sits in an output register, so a finished
// result may wait on out_ch while the next request is taken.
module buddy_allocator_core (
  input  logic     clk,
  input  logic     rst_n,
  ba_req_if.sink   in_ch,
  ba_rsp_if.source out_ch,
  ba_cfg_if.sink   cfg_ch
);

  ba_pkg::dp_cmd_t cmd;
  ba_pkg::dp_sts_t sts;

  // sequencer: owns request acceptance
  ba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: memories, payload and result registers
  ba_dp u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch),
    .cmd    (cmd),
    .sts    (sts)
  );

endmodule

// ----- hw/rtl/ba_ctrl.sv -----
// Buddy allocator sequencer: walks allocate and free requests through the
// datapath. Depends on ba_pkg.
module ba_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  ba_pkg::dp_sts_t sts,
  output ba_pkg::dp_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_DISP, S_A_LVL, S_A_RD, S_A_CHK, S_S_STEP, S_S_DOWN, S_A_REC,
    S_F_RD, S_F_LVL, S_M_CHK, S_M_TST, S_M_UP, S_RMW_RD, S_RMW_WR, S_FIN
  } state_t;

  state_t       state_r, state_nxt, ret_r, ret_nxt;
  ba_pkg::rmw_t mode_r, mode_nxt;
  logic [1:0]   st_r, st_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    ret_nxt    = ret_r;
    mode_nxt   = mode_r;
    st_nxt     = st_r;
    cmd.op     = ba_pkg::DP_NOP;
    cmd.rmw    = mode_r;
    cmd.fin    = 1'b0;
    cmd.status = st_r;
    case (state_r)
      S_CLR: begin
        cmd.op = ba_pkg::DP_CLEAR;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = ba_pkg::DP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: state_nxt = sts.is_free ? S_F_RD : S_A_LVL;
      S_A_LVL: begin
        if (sts.lvl_top) begin
          st_nxt    = ba_pkg::STS_NOSPACE;
          state_nxt = S_FIN;
        end else if (sts.size_above) begin
          cmd.op = ba_pkg::DP_LVL_INC;
        end else begin
          cmd.op    = ba_pkg::DP_SEARCH_INIT;
          state_nxt = S_A_RD;
        end
      end
      S_A_RD: begin
        cmd.op    = ba_pkg::DP_READ_SCAN;
        state_nxt = S_A_CHK;
      end
      S_A_CHK: begin
        if (sts.hit) begin
          cmd.op    = ba_pkg::DP_SCAN_HIT;
          state_nxt = S_S_STEP;
        end else if (!sts.wcnt_last) begin
          cmd.op    = ba_pkg::DP_WCNT_INC;
          state_nxt = S_A_RD;
        end else if (!sts.lvl_max) begin
          cmd.op    = ba_pkg::DP_LVL_NEXT;
          state_nxt = S_A_RD;
        end else begin
          st_nxt    = ba_pkg::STS_NOSPACE;
          state_nxt = S_FIN;
        end
      end
      S_S_STEP: begin
        mode_nxt  = ba_pkg::RMW_CLR1;
        ret_nxt   = sts.lvl_eq_tgt ? S_A_REC : S_S_DOWN;
        state_nxt = S_RMW_RD;
      end
      S_S_DOWN: begin
        cmd.op    = ba_pkg::DP_SPLIT_DOWN;
        mode_nxt  = ba_pkg::RMW_SET2;
        ret_nxt   = S_S_STEP;
        state_nxt = S_RMW_RD;
      end
      S_A_REC: begin
        cmd.op    = ba_pkg::DP_RECORD;
        st_nxt    = ba_pkg::STS_OK;
        state_nxt = S_FIN;
      end
      S_F_RD: begin
        if (sts.unit_oob) begin
          st_nxt    = ba_pkg::STS_BADFREE;
          state_nxt = S_FIN;
        end else begin
          cmd.op    = ba_pkg::DP_UNIT_RD;
          state_nxt = S_F_LVL;
        end
      end
      S_F_LVL: begin
        if (sts.lv_bad) begin
          st_nxt    = ba_pkg::STS_BADFREE;
          state_nxt = S_FIN;
        end else begin
          cmd.op    = ba_pkg::DP_FREE_START;
          mode_nxt  = ba_pkg::RMW_SET1;
          ret_nxt   = S_M_CHK;
          state_nxt = S_RMW_RD;
        end
      end
      S_M_CHK: begin
        if (sts.lvl_max) begin
          st_nxt    = ba_pkg::STS_OK;
          state_nxt = S_FIN;
        end else begin
          cmd.op    = ba_pkg::DP_RMW_RD;
          state_nxt = S_M_TST;
        end
      end
      S_M_TST: begin
        if (sts.pair_free) begin
          mode_nxt  = ba_pkg::RMW_CLR2;
          ret_nxt   = S_M_UP;
          state_nxt = S_RMW_RD;
        end else begin
          st_nxt    = ba_pkg::STS_OK;
          state_nxt = S_FIN;
        end
      end
      S_M_UP: begin
        cmd.op    = ba_pkg::DP_MERGE_UP;
        mode_nxt  = ba_pkg::RMW_SET1;
        ret_nxt   = S_M_CHK;
        state_nxt = S_RMW_RD;
      end
      S_RMW_RD: begin
        cmd.op    = ba_pkg::DP_RMW_RD;
        state_nxt = S_RMW_WR;
      end
      S_RMW_WR: begin
        cmd.op    = ba_pkg::DP_RMW_WR;
        state_nxt = ret_r;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      ret_r   <= S_IDLE;
      mode_r  <= ba_pkg::RMW_SET1;
      st_r    <= ba_pkg::STS_OK;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      mode_r  <= mode_nxt;
      st_r    <= st_nxt;
    end
  end

endmodule

// ----- hw/rtl/ba_dp.sv -----
// Buddy allocator datapath: free-flag word memory, unit level memory, request
// registers, result register and shift register. Depends on ba_pkg, ba_if.
module ba_dp (
  input  logic            clk,
  input  logic            rst_n,
  ba_req_if.sink          in_ch,
  ba_rsp_if.source        out_ch,
  ba_cfg_if.sink          cfg_ch,
  input  ba_pkg::dp_cmd_t cmd,
  output ba_pkg::dp_sts_t sts
);

  logic [ba_pkg::WORD_W-1:0] flag_mem [ba_pkg::WORDS];
  logic [ba_pkg::LVL_W-1:0]  lvl_mem  [ba_pkg::UNIT_CNT];

  logic [ba_pkg::WORD_W-1:0] frd_r;
  logic [ba_pkg::LVL_W-1:0]  lrd_r;
  logic [4:0]                shift_r;
  logic                      cmd_r;
  logic [28:0]               size_r;
  logic [27:0]               off_r, boff_r, out_off_r;
  logic [ba_pkg::LVL_W-1:0]  lvl_r, tgt_r;
  logic [ba_pkg::UNIT_W-1:0] idx_r, clr_r;
  logic [ba_pkg::WC_W-1:0]   wcnt_r;
  logic                      out_valid_r;
  logic [1:0]                out_sts_r;

  logic [5:0]                sh_sum;
  logic [ba_pkg::FA_W-1:0]   scan_addr, blk_addr;
  logic [ba_pkg::WB-1:0]     bitpos, pairpos, pe;
  logic [27:0]               unit_full;
  logic [ba_pkg::UNIT_W-1:0] unit, rec_unit;
  logic                      fwe, lwe, fre, lre;
  logic [ba_pkg::FA_W-1:0]   fwaddr, fraddr;
  logic [ba_pkg::UNIT_W-1:0] lwaddr, lraddr;
  logic [ba_pkg::WORD_W-1:0] fwdata, rmw_data;
  logic [ba_pkg::LVL_W-1:0]  lwdata;

  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_sts_r;
  assign out_ch.block_offset = out_off_r;

  assign sh_sum    = 6'(shift_r) + 6'(lvl_r);
  assign scan_addr = ba_pkg::FA_W'(ba_pkg::base_of(int'(lvl_r)) + int'(wcnt_r));
  assign blk_addr  = ba_pkg::FA_W'(ba_pkg::base_of(int'(lvl_r)) + int'(idx_r >> ba_pkg::WB));
  assign bitpos    = ba_pkg::WB'(idx_r);
  assign pairpos   = {bitpos[ba_pkg::WB-1:1], 1'b0};
  assign unit_full = off_r >> shift_r;
  assign unit      = ba_pkg::UNIT_W'(unit_full);
  assign rec_unit  = ba_pkg::UNIT_W'(idx_r << lvl_r);

  // lowest set flag of the word just read
  always_comb begin
    pe = '0;
    for (int i = ba_pkg::WORD_W - 1; i >= 0; i--) begin
      if (frd_r[i]) pe = ba_pkg::WB'(i);
    end
  end

  always_comb begin
    rmw_data = frd_r;
    case (cmd.rmw)
      ba_pkg::RMW_SET1: rmw_data[bitpos] = 1'b1;
      ba_pkg::RMW_CLR1: rmw_data[bitpos] = 1'b0;
      ba_pkg::RMW_SET2: begin
        rmw_data[pairpos]        = 1'b1;
        rmw_data[pairpos | 4'd1] = 1'b1;
      end
      ba_pkg::RMW_CLR2: begin
        rmw_data[pairpos]        = 1'b0;
        rmw_data[pairpos | 4'd1] = 1'b0;
      end
      default: rmw_data = frd_r;
    endcase
  end

  always_comb begin
    sts.clr_done   = (clr_r == '1);
    sts.is_free    = (cmd_r == ba_pkg::CMD_FREE);
    sts.lvl_top    = (lvl_r == ba_pkg::LVL_W'(ba_pkg::LVL_CNT));
    sts.lvl_max    = (lvl_r == ba_pkg::LVL_W'(ba_pkg::LVL_CNT - 1));
    sts.lvl_eq_tgt = (lvl_r == tgt_r);
    sts.size_above = (sh_sum < 6'd29) && ((29'd1 << sh_sum) < size_r);
    sts.hit        = |frd_r;
    sts.wcnt_last  = (int'(wcnt_r) + 1 >= ba_pkg::words_of(int'(lvl_r)));
    sts.unit_oob   = |(unit_full >> ba_pkg::UNIT_W);
    sts.lv_bad     = (lrd_r == ba_pkg::UNALLOC) ||
                     (lrd_r >= ba_pkg::LVL_W'(ba_pkg::LVL_CNT));
    sts.pair_free  = frd_r[pairpos] && frd_r[pairpos | 4'd1];
    sts.out_free   = !out_valid_r || out_ch.ready;
  end

  // memory port steering
  always_comb begin
    fwe    = 1'b0;
    fwaddr = blk_addr;
    fwdata = rmw_data;
    fre    = 1'b0;
    fraddr = blk_addr;
    lwe    = 1'b0;
    lwaddr = unit;
    lwdata = ba_pkg::UNALLOC;
    lre    = 1'b0;
    lraddr = unit;
    case (cmd.op)
      ba_pkg::DP_CLEAR: begin
        fwe    = (int'(clr_r) < ba_pkg::WORDS);
        fwaddr = ba_pkg::FA_W'(clr_r);
        fwdata = (int'(clr_r) == ba_pkg::WORDS - 1) ? ba_pkg::WORD_W'(1) : '0;
        lwe    = 1'b1;
        lwaddr = clr_r;
      end
      ba_pkg::DP_READ_SCAN: begin
        fre    = 1'b1;
        fraddr = scan_addr;
      end
      ba_pkg::DP_RMW_RD:     fre = 1'b1;
      ba_pkg::DP_RMW_WR:     fwe = 1'b1;
      ba_pkg::DP_UNIT_RD:    lre = 1'b1;
      ba_pkg::DP_FREE_START: lwe = 1'b1;
      ba_pkg::DP_RECORD: begin
        lwe    = 1'b1;
        lwaddr = rec_unit;
        lwdata = lvl_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (fwe) flag_mem[fwaddr] <= fwdata;
    if (fre) frd_r <= flag_mem[fraddr];
    if (lwe) lvl_mem[lwaddr] <= lwdata;
    if (lre) lrd_r <= lvl_mem[lraddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r     <= 5'd6;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) shift_r <= cfg_ch.data;
      if (cmd.op == ba_pkg::DP_CLEAR) clr_r <= clr_r + 1'b1;
      if (cmd.fin) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_sts_r <= cmd.status;
      out_off_r <= (cmd.status == ba_pkg::STS_OK) ? boff_r : '0;
    end
    case (cmd.op)
      ba_pkg::DP_LOAD: begin
        cmd_r  <= in_ch.command;
        size_r <= in_ch.req_size;
        off_r  <= in_ch.free_offset;
        lvl_r  <= '0;
        boff_r <= '0;
      end
      ba_pkg::DP_LVL_INC:     lvl_r <= lvl_r + 1'b1;
      ba_pkg::DP_SEARCH_INIT: begin
        tgt_r  <= lvl_r;
        wcnt_r <= '0;
      end
      ba_pkg::DP_WCNT_INC:    wcnt_r <= wcnt_r + 1'b1;
      ba_pkg::DP_LVL_NEXT: begin
        lvl_r  <= lvl_r + 1'b1;
        wcnt_r <= '0;
      end
      ba_pkg::DP_SCAN_HIT:    idx_r <= ba_pkg::UNIT_W'({wcnt_r, pe});
      ba_pkg::DP_SPLIT_DOWN: begin
        idx_r <= idx_r << 1;
        lvl_r <= lvl_r - 1'b1;
      end
      ba_pkg::DP_MERGE_UP: begin
        idx_r <= idx_r >> 1;
        lvl_r <= lvl_r + 1'b1;
      end
      ba_pkg::DP_FREE_START: begin
        lvl_r <= lrd_r;
        idx_r <= unit >> lrd_r;
      end
      ba_pkg::DP_RECORD:      boff_r <= 28'(rec_unit) << shift_r;
      default: ;
    endcase
  end

endmodule

// ----- hw/rtl/ba_checker.sv -----
// Port-level checks for the buddy allocator, bound to its top level.
// Depends on ba_pkg, buddy_allocator_core.
module ba_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [27:0] out_offset
);

  // hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_offset))
    else $error("result changed while stalled");

  a_zero_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ba_pkg::STS_OK) |-> (out_offset == 28'd0))
    else $error("failed request carries an offset");

  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= ba_pkg::STS_BADFREE))
    else $error("undefined status code");

  // requests wait for the clearing pass
  a_clear: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("request taken before memories cleared");

endmodule

bind buddy_allocator_core ba_checker u_ba_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_offset (out_ch.block_offset)
);
